[rtl/pdrt_pkg.sv]
// ----------------------------------------------------------------------------
// pdrt_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the prescaled dual reload timer.
// ----------------------------------------------------------------------------
package pdrt_pkg;

  // Field widths
  localparam int COUNTER_BITS = 8;
  localparam int CNT_W        = COUNTER_BITS;
  localparam int CYC_W        = 6;
  localparam int DLY_W        = 4;
  localparam int TICK_W       = 9;              // ticks and wrap remainders, max 318
  localparam int PDIV_W       = 9;
  localparam int DVSR_W       = 2 * CNT_W + 1;  // holds a 16-bit period of 65536
  localparam int IN_W         = 16;
  localparam int OUT_W        = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 9;

  localparam logic [CYC_W-1:0]  MAX_CYCLES = 6'd63;
  localparam logic [PDIV_W-1:0] PDIV_MAX   = 9'd256;
  localparam logic [CNT_W:0]    MOD8       = 9'h100;
  localparam logic [DVSR_W-1:0] MOD16      = 17'h10000;

  // Divider: 3 quotient bits per clock over a 9-bit dividend
  localparam int DIV_STEPS = 3;
  localparam int DIV_ITERS = TICK_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_IRQ_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_IRQ_EN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_RELOAD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_RELOAD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE    = 3'd7;

  // Divider operand select
  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DSEL_PRESCALE = 2'd0;
  localparam div_sel_t DSEL_LOW      = 2'd1;
  localparam div_sel_t DSEL_HIGH     = 2'd2;

  typedef struct packed {
    logic     capture;
    logic     prep;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_prescale;
    logic     tick;
    logic     fix_low;
    logic     fix_high;
    logic     out_load;
  } pdrt_cmd_t;

  typedef struct packed {
    logic running;
    logic ticks_zero;
    logic wrap_low;
    logic wrap_high;
    logic div_done;
    logic out_free;
  } pdrt_status_t;

endpackage

[rtl/prescaled_dual_reload_timer.sv]
// ----------------------------------------------------------------------------
// prescaled_dual_reload_timer
// Prescaled timer with two 8-bit auto-reload counters that can be joined
// into one 16-bit counter.
// ----------------------------------------------------------------------------
// Each input transaction reports elapsed CPU time; the block swallows any
// pending start delay, divides the rest (plus the prescaler remainder) by the
// prescale divisor, advances the counters by the quotient and returns one
// result transaction with both counter bytes, the sticky overflow flags and
// the interrupts raised in that step. One transaction is in flight at a time.
// The time from acceptance to the result depends on whether the halves run
// and on how many counters wrap. The shared divider, which produces 3 quotient
// bits per clock, is used once for the prescaler when a half runs and once
// more for each wrapping counter, and not at all with both halves stopped.
// The result register lets the next input be accepted while a result waits
// on out_tready. Configuration writes are always taken (cfg_ready is tied
// high) and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module prescaled_dual_reload_timer (
  input  logic                              clk,
  input  logic                              rst_n,

  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [5:0] cycles, [6] load_delay, [10:7] start_delay, [11] clear_low_flag,
  // [12] clear_high_flag, [15:13] zero
  input  logic [pdrt_pkg::IN_W-1:0]         in_tdata,

  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] low_value, [15:8] high_value, [16] low_overflow_flag,
  // [17] high_overflow_flag, [18] low_irq, [19] high_irq, [23:20] zero
  output logic [pdrt_pkg::OUT_W-1:0]        out_tdata,

  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdrt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pdrt_pkg::*;

  pdrt_cmd_t    cmd;
  pdrt_status_t status;

  // registers live in flops, so every write is accepted
  assign cfg_ready = 1'b1;

  pdrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pdrt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

[rtl/pdrt_div.sv]
// ----------------------------------------------------------------------------
// pdrt_div
// Iterative restoring divider, 9-bit dividend by 17-bit divisor, three
// quotient bits per clock.
// ----------------------------------------------------------------------------
module pdrt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pdrt_pkg::TICK_W-1:0]   dividend,
  input  logic [pdrt_pkg::DVSR_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [pdrt_pkg::TICK_W-1:0]   quo,
  output logic [pdrt_pkg::TICK_W-1:0]   rem
);
  import pdrt_pkg::*;

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TICK_W-1:0]    dq_r, dq_nxt;
  logic [TICK_W-1:0]    rem_r, rem_nxt;
  logic [DVSR_W-1:0]    dvsr_r;

  // dq_r shifts dividend bits out at the top and quotient bits in below
  always_comb begin
    logic [TICK_W-1:0] r_v;
    logic [TICK_W-1:0] q_v;
    logic [TICK_W:0]   t_v;
    logic [DVSR_W-1:0] d_v;
    logic              ge_v;
    r_v = rem_r;
    q_v = dq_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t_v  = {r_v, q_v[TICK_W-1]};
      ge_v = {{(DVSR_W-TICK_W-1){1'b0}}, t_v} >= dvsr_r;
      d_v  = {{(DVSR_W-TICK_W-1){1'b0}}, t_v} - dvsr_r;
      r_v  = ge_v ? d_v[TICK_W-1:0] : t_v[TICK_W-1:0];
      q_v  = {q_v[TICK_W-2:0], ge_v};
    end
    dq_nxt  = q_v;
    rem_nxt = r_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_ITERS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r   <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = dq_r;
  assign rem  = rem_r;

endmodule

[rtl/pdrt_datapath.sv]
// ----------------------------------------------------------------------------
// pdrt_datapath
// Configuration registers, timer state, prescaler and counter arithmetic,
// shared divider and the result register.
// ----------------------------------------------------------------------------
module pdrt_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pdrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdrt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [pdrt_pkg::IN_W-1:0]         in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pdrt_pkg::OUT_W-1:0]        out_tdata,
  input  pdrt_pkg::pdrt_cmd_t               cmd,
  output pdrt_pkg::pdrt_status_t            status
);
  import pdrt_pkg::*;

  // configuration
  logic              run_low_r, run_high_r, long_mode_r, low_ie_r, high_ie_r;
  logic [CNT_W-1:0]  low_reload_r, high_reload_r;
  logic [PDIV_W-1:0] pdiv_r;

  // timer state
  logic [CNT_W-1:0]  low_cnt_r, low_cnt_nxt, high_cnt_r, high_cnt_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [DLY_W-1:0]  delay_r, delay_nxt;
  logic              low_flag_r, low_flag_nxt, high_flag_r, high_flag_nxt;

  // per-transaction work registers
  logic [CYC_W-1:0]  cyc_r, cyc_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt, rem_lo_r, rem_lo_nxt, rem_hi_r, rem_hi_nxt;
  logic              wrap_lo_r, wrap_lo_nxt, wrap_hi_r, wrap_hi_nxt;
  logic              irq_lo_r, irq_lo_nxt, irq_hi_r, irq_hi_nxt;

  // result register
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  // input fields
  logic [CYC_W-1:0]  in_cycles;
  logic              in_load_delay, in_clr_low, in_clr_high;
  logic [DLY_W-1:0]  in_start_delay;

  assign in_cycles      = in_tdata[5:0];
  assign in_load_delay  = in_tdata[6];
  assign in_start_delay = in_tdata[10:7];
  assign in_clr_low     = in_tdata[11];
  assign in_clr_high    = in_tdata[12];

  logic              running, long_en;
  logic [CYC_W-1:0]  skip;
  logic [TICK_W-1:0] sum;
  logic [PDIV_W-1:0] div_eff;
  logic [CNT_W:0]    per_lo, per_hi, tov_lo, tov_hi;
  logic [DVSR_W-1:0] per_long, tov16;
  logic [2*CNT_W-1:0] v16, long_sum, long_fix;
  logic              long_wrap, lo_wrap, hi_wrap;

  // divider
  logic              div_busy, div_done;
  logic [TICK_W-1:0] div_dividend, div_quo, div_rem;
  logic [DVSR_W-1:0] div_divisor;

  assign running = run_low_r | run_high_r;
  assign long_en = long_mode_r & run_low_r & run_high_r;

  assign skip    = ({2'b00, delay_r} < cyc_r) ? {2'b00, delay_r} : cyc_r;
  assign sum     = {1'b0, acc_r} + {3'b000, CYC_W'(cyc_r - skip)};
  assign div_eff = (pdiv_r == '0 || pdiv_r > PDIV_MAX) ? PDIV_MAX : pdiv_r;

  assign per_lo   = MOD8 - {1'b0, low_reload_r};
  assign per_hi   = MOD8 - {1'b0, high_reload_r};
  assign per_long = MOD16 - {1'b0, high_reload_r, low_reload_r};

  assign v16       = {high_cnt_r, low_cnt_r};
  assign tov16     = MOD16 - {1'b0, v16};
  assign long_wrap = {{(DVSR_W-TICK_W){1'b0}}, ticks_r} >= tov16;
  assign long_sum  = v16 + {{(2*CNT_W-TICK_W){1'b0}}, ticks_r};
  assign long_fix  = {high_reload_r, low_reload_r} + {{(2*CNT_W-TICK_W){1'b0}}, div_rem};

  assign tov_lo  = MOD8 - {1'b0, low_cnt_r};
  assign tov_hi  = MOD8 - {1'b0, high_cnt_r};
  assign lo_wrap = ticks_r >= tov_lo;
  assign hi_wrap = ticks_r >= tov_hi;

  always_comb begin
    case (cmd.div_sel)
      DSEL_LOW: begin
        div_dividend = rem_lo_r;
        div_divisor  = long_en ? per_long : {{(DVSR_W-CNT_W-1){1'b0}}, per_lo};
      end
      DSEL_HIGH: begin
        div_dividend = rem_hi_r;
        div_divisor  = {{(DVSR_W-CNT_W-1){1'b0}}, per_hi};
      end
      default: begin
        div_dividend = sum;
        div_divisor  = {{(DVSR_W-PDIV_W){1'b0}}, div_eff};
      end
    endcase
  end

  pdrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    low_cnt_nxt   = low_cnt_r;
    high_cnt_nxt  = high_cnt_r;
    acc_nxt       = acc_r;
    delay_nxt     = delay_r;
    low_flag_nxt  = low_flag_r;
    high_flag_nxt = high_flag_r;
    cyc_nxt       = cyc_r;
    ticks_nxt     = ticks_r;
    rem_lo_nxt    = rem_lo_r;
    rem_hi_nxt    = rem_hi_r;
    wrap_lo_nxt   = wrap_lo_r;
    wrap_hi_nxt   = wrap_hi_r;
    irq_lo_nxt    = irq_lo_r;
    irq_hi_nxt    = irq_hi_r;

    if (cmd.capture) begin
      // flag clears first, then the delay load
      cyc_nxt     = (in_cycles > MAX_CYCLES) ? MAX_CYCLES : in_cycles;
      wrap_lo_nxt = 1'b0;
      wrap_hi_nxt = 1'b0;
      irq_lo_nxt  = 1'b0;
      irq_hi_nxt  = 1'b0;
      ticks_nxt   = '0;
      if (in_clr_low)    low_flag_nxt  = 1'b0;
      if (in_clr_high)   high_flag_nxt = 1'b0;
      if (in_load_delay) delay_nxt     = in_start_delay;
    end

    if (cmd.prep && running) begin
      delay_nxt = delay_r - skip[DLY_W-1:0];
    end

    if (cmd.take_prescale) begin
      acc_nxt   = div_rem[CNT_W-1:0];
      ticks_nxt = div_quo;
    end

    if (cmd.tick) begin
      if (long_en) begin
        if (long_wrap) begin
          low_flag_nxt  = 1'b1;
          high_flag_nxt = 1'b1;
          irq_hi_nxt    = high_ie_r;
          wrap_lo_nxt   = 1'b1;
          rem_lo_nxt    = ticks_r - tov16[TICK_W-1:0];
        end else begin
          {high_cnt_nxt, low_cnt_nxt} = long_sum;
        end
      end else begin
        if (run_low_r) begin
          if (lo_wrap) begin
            low_flag_nxt = 1'b1;
            irq_lo_nxt   = low_ie_r;
            wrap_lo_nxt  = 1'b1;
            rem_lo_nxt   = ticks_r - tov_lo;
          end else begin
            low_cnt_nxt = low_cnt_r + ticks_r[CNT_W-1:0];
          end
        end
        if (run_high_r) begin
          if (hi_wrap) begin
            high_flag_nxt = 1'b1;
            irq_hi_nxt    = high_ie_r;
            wrap_hi_nxt   = 1'b1;
            rem_hi_nxt    = ticks_r - tov_hi;
          end else begin
            high_cnt_nxt = high_cnt_r + ticks_r[CNT_W-1:0];
          end
        end
      end
    end

    // restart from the reload value plus what is left of the period
    if (cmd.fix_low) begin
      if (long_en) begin
        {high_cnt_nxt, low_cnt_nxt} = long_fix;
      end else begin
        low_cnt_nxt = low_reload_r + div_rem[CNT_W-1:0];
      end
    end
    if (cmd.fix_high) begin
      high_cnt_nxt = high_reload_r + div_rem[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_low_r     <= 1'b0;
      run_high_r    <= 1'b0;
      long_mode_r   <= 1'b0;
      low_ie_r      <= 1'b0;
      high_ie_r     <= 1'b0;
      low_reload_r  <= '0;
      high_reload_r <= '0;
      pdiv_r        <= PDIV_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RUN_LOW:     run_low_r     <= cfg_data[0];
        REG_RUN_HIGH:    run_high_r    <= cfg_data[0];
        REG_LONG_MODE:   long_mode_r   <= cfg_data[0];
        REG_LOW_IRQ_EN:  low_ie_r      <= cfg_data[0];
        REG_HIGH_IRQ_EN: high_ie_r     <= cfg_data[0];
        REG_LOW_RELOAD:  low_reload_r  <= cfg_data[CNT_W-1:0];
        REG_HIGH_RELOAD: high_reload_r <= cfg_data[CNT_W-1:0];
        REG_PRESCALE:    pdiv_r        <= cfg_data[PDIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r   <= '0;
      high_cnt_r  <= '0;
      acc_r       <= '0;
      delay_r     <= '0;
      low_flag_r  <= 1'b0;
      high_flag_r <= 1'b0;
      wrap_lo_r   <= 1'b0;
      wrap_hi_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      low_cnt_r   <= low_cnt_nxt;
      high_cnt_r  <= high_cnt_nxt;
      acc_r       <= acc_nxt;
      delay_r     <= delay_nxt;
      low_flag_r  <= low_flag_nxt;
      high_flag_r <= high_flag_nxt;
      wrap_lo_r   <= wrap_lo_nxt;
      wrap_hi_r   <= wrap_hi_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cyc_r    <= cyc_nxt;
    ticks_r  <= ticks_nxt;
    rem_lo_r <= rem_lo_nxt;
    rem_hi_r <= rem_hi_nxt;
    irq_lo_r <= irq_lo_nxt;
    irq_hi_r <= irq_hi_nxt;
    if (cmd.out_load) begin
      out_data_r <= {4'b0000, irq_hi_r, irq_lo_r, high_flag_r, low_flag_r,
                     high_cnt_r, low_cnt_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign status.running    = running;
  assign status.ticks_zero = (ticks_r == '0);
  assign status.wrap_low   = wrap_lo_r;
  assign status.wrap_high  = wrap_hi_r;
  assign status.div_done   = div_done;
  assign status.out_free   = ~out_valid_r | out_tready;

  // assertions
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_acc_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_prescale |=> ({1'b0, acc_r} < div_eff))
    else $error("prescaler remainder not below divisor");

  a_long_wrap_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick && long_en && long_wrap) |=> (low_flag_r && high_flag_r))
    else $error("16-bit wrap did not set both flags");

  a_irq_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[18]) |-> out_data_r[16])
    else $error("low interrupt without low flag");

endmodule

[rtl/pdrt_ctrl.sv]
// ----------------------------------------------------------------------------
// pdrt_ctrl
// Sequencer: capture, prescale divide, counter advance, wrap fix-ups and
// result hand-off.
// ----------------------------------------------------------------------------
module pdrt_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  pdrt_pkg::pdrt_status_t  status,
  output pdrt_pkg::pdrt_cmd_t     cmd
);
  import pdrt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_PWAIT = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_LWAIT = 3'd5;
  localparam logic [2:0] S_HWAIT = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DSEL_PRESCALE;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (status.running) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_PWAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PWAIT: begin
        if (status.div_done) begin
          cmd.take_prescale = 1'b1;
          state_nxt         = S_TICK;
        end
      end
      S_TICK: begin
        if (status.ticks_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.tick  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (status.wrap_low) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_LOW;
          state_nxt     = S_LWAIT;
        end else if (status.wrap_high) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_HIGH;
          state_nxt     = S_HWAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_LWAIT: begin
        if (status.div_done) begin
          cmd.fix_low = 1'b1;
          if (status.wrap_high) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_HIGH;
            state_nxt     = S_HWAIT;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_HWAIT: begin
        if (status.div_done) begin
          cmd.fix_high = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
